// File: hw/rtl/edcr_pkg.sv
`timescale 1ns / 1ps

package edcr_pkg;

    // Field widths
    localparam int VW   = 24;          // Q15.8 velocity / position
    localparam int MW   = 16;          // Q8.8 mass
    localparam int DW   = 66;          // (m1+m2) * |d|^2
    localparam int AW   = 42;          // |dc| * 2m
    localparam int SW   = 50;          // s magnitude when s > 0
    localparam int SH   = 25;          // split point of s for the numerator multiply
    localparam int NW   = 92;          // 2 * |dc| * 2m * s
    localparam int QW   = 28;          // quotient bits, one below the Q.8 step
    localparam int NL   = 4;           // change terms: first x, first y, second x, second y

    localparam logic [26:0] DELTA_CLAMP = 27'd67108864;
    localparam logic signed [28:0] VEL_MAX = 29'sd8388607;
    localparam logic signed [28:0] VEL_MIN = -29'sd8388608;

    // Payload that rides along the whole pipeline
    typedef struct packed {
        logic [VW-1:0] v1x;
        logic [VW-1:0] v1y;
        logic [VW-1:0] v2x;
        logic [VW-1:0] v2y;
        logic [NL-1:0] neg;   // sign of the separation component per lane
        logic          hit;   // discs approaching
    } side_t;

endpackage

// File: hw/rtl/elastic_disc_collision_response.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled; five arithmetic stages, then a
// 28-stage restoring divider (one quotient bit per stage, four lanes).
// The whole pipeline advances together and holds while m_tvalid waits on m_tready.
// Reset: synchronous, active-low aresetn clears all stage valid bits.
module elastic_disc_collision_response
    import edcr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x,
    // first_vel_y, second_vel_x, second_vel_y, first_mass, second_mass
    input  logic [223:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
    output logic [95:0]  m_tdata,
    // collided
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: differences, mass fixup
    logic signed [VW:0] dx_reg, dy_reg, rx_reg, ry_reg;
    logic [MW-1:0]      m1_reg, m2_reg;
    side_t              sd1_reg;
    logic               vl1_reg;

    logic signed [VW-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    logic [MW-1:0]        m1i, m2i;
    assign p1x = s_tdata[23:0];
    assign p1y = s_tdata[47:24];
    assign p2x = s_tdata[71:48];
    assign p2y = s_tdata[95:72];
    assign v1x = s_tdata[119:96];
    assign v1y = s_tdata[143:120];
    assign v2x = s_tdata[167:144];
    assign v2y = s_tdata[191:168];
    assign m1i = s_tdata[207:192];
    assign m2i = s_tdata[223:208];

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg      <= (VW+1)'(p2x) - (VW+1)'(p1x);
            dy_reg      <= (VW+1)'(p2y) - (VW+1)'(p1y);
            rx_reg      <= (VW+1)'(v1x) - (VW+1)'(v2x);
            ry_reg      <= (VW+1)'(v1y) - (VW+1)'(v2y);
            m1_reg      <= (m1i == '0) ? MW'(1) : m1i;
            m2_reg      <= (m2i == '0) ? MW'(1) : m2i;
            sd1_reg.v1x <= v1x;
            sd1_reg.v1y <= v1y;
            sd1_reg.v2x <= v2x;
            sd1_reg.v2y <= v2y;
            sd1_reg.neg <= '0;
            sd1_reg.hit <= 1'b0;
        end
    end

    // ---------------- stage 2: products
    logic signed [2*VW+1:0] dxrx_reg, dyry_reg, dxdx_reg, dydy_reg;
    logic [AW-1:0]          a2_reg [NL];
    logic [MW:0]            msum2_reg;
    side_t                  sd2_reg;
    logic                   vl2_reg;

    logic [VW:0] adx, ady;
    assign adx = dx_reg[VW] ? (VW+1)'(-dx_reg) : dx_reg;
    assign ady = dy_reg[VW] ? (VW+1)'(-dy_reg) : dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dxrx_reg  <= dx_reg * rx_reg;
            dyry_reg  <= dy_reg * ry_reg;
            dxdx_reg  <= dx_reg * dx_reg;
            dydy_reg  <= dy_reg * dy_reg;
            a2_reg[0] <= AW'(adx * {m2_reg, 1'b0});
            a2_reg[1] <= AW'(ady * {m2_reg, 1'b0});
            a2_reg[2] <= AW'(adx * {m1_reg, 1'b0});
            a2_reg[3] <= AW'(ady * {m1_reg, 1'b0});
            msum2_reg <= (MW+1)'(m1_reg) + (MW+1)'(m2_reg);
            sd2_reg   <= {sd1_reg.v1x, sd1_reg.v1y, sd1_reg.v2x, sd1_reg.v2y,
                          dy_reg[VW], dx_reg[VW], dy_reg[VW], dx_reg[VW], sd1_reg.hit};
        end
    end

    // ---------------- stage 3: dot product and squared distance
    logic [SW-1:0]  s3_reg;
    logic [SW-2:0]  dsq3_reg;
    logic [AW-1:0]  a3_reg [NL];
    logic [MW:0]    msum3_reg;
    side_t          sd3_reg;
    logic           vl3_reg;

    logic signed [2*VW+2:0] s_sum;
    assign s_sum = (2*VW+3)'(dxrx_reg) + (2*VW+3)'(dyry_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg      <= s_sum[SW-1:0];
            dsq3_reg    <= (SW-1)'(dxdx_reg) + (SW-1)'(dydy_reg);
            a3_reg      <= a2_reg;
            msum3_reg   <= msum2_reg;
            sd3_reg     <= {sd2_reg.v1x, sd2_reg.v1y, sd2_reg.v2x, sd2_reg.v2y,
                            sd2_reg.neg, (s_sum > 0)};
        end
    end

    // ---------------- stage 4: denominator and split numerator products
    logic [DW-1:0]       den4_reg;
    logic [AW+SH-1:0]    plo4_reg [NL];
    logic [AW+SH-1:0]    phi4_reg [NL];
    side_t               sd4_reg;
    logic                vl4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den4_reg <= DW'(msum3_reg * dsq3_reg);
            for (int l = 0; l < NL; l++) begin
                plo4_reg[l] <= a3_reg[l] * s3_reg[SH-1:0];
                phi4_reg[l] <= a3_reg[l] * s3_reg[SW-1:SH];
            end
            sd4_reg <= sd3_reg;
        end
    end

    // ---------------- stage 5: full numerator, divider entry
    logic [DW-1:0] den_reg [QW+1];
    logic [DW-1:0] rem_reg [QW+1][NL];
    logic [QW-1:0] low_reg [QW+1][NL];
    logic [QW-1:0] quo_reg [QW+1][NL];
    side_t         sdd_reg [QW+1];
    logic          vld_reg [QW+1];

    logic [NW-1:0] num2 [NL];
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            num2[l] = ((NW'(phi4_reg[l]) << SH) + NW'(plo4_reg[l])) << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den4_reg;
            sdd_reg[0] <= sd4_reg;
            for (int l = 0; l < NL; l++) begin
                rem_reg[0][l] <= DW'(num2[l][NW-1:QW]);
                low_reg[0][l] <= num2[l][QW-1:0];
                quo_reg[0][l] <= '0;
            end
        end
    end

    // ---------------- divider: one quotient bit per stage
    for (genvar j = 1; j <= QW; j++) begin : g_div
        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [DW:0] trial;
            logic [DW:0] diff;
            assign trial = {rem_reg[j-1][l], low_reg[j-1][l][QW-1]};
            assign diff  = trial - {1'b0, den_reg[j-1]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (trial >= {1'b0, den_reg[j-1]}) begin
                        rem_reg[j][l] <= diff[DW-1:0];
                        quo_reg[j][l] <= {quo_reg[j-1][l][QW-2:0], 1'b1};
                    end else begin
                        rem_reg[j][l] <= trial[DW-1:0];
                        quo_reg[j][l] <= {quo_reg[j-1][l][QW-2:0], 1'b0};
                    end
                    low_reg[j][l] <= {low_reg[j-1][l][QW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j] <= den_reg[j-1];
                sdd_reg[j] <= sdd_reg[j-1];
            end
        end
    end

    // ---------------- output: round, apply, saturate
    logic signed [VW-1:0] vin  [NL];
    logic signed [VW-1:0] vout [NL];
    side_t                sdo;
    always_comb begin
        logic [QW:0]          qr;
        logic [26:0]          mag;
        logic signed [28:0]   delta;
        logic signed [28:0]   sum;
        sdo    = sdd_reg[QW];
        vin[0] = sdo.v1x;
        vin[1] = sdo.v1y;
        vin[2] = sdo.v2x;
        vin[3] = sdo.v2y;
        for (int l = 0; l < NL; l++) begin
            qr    = ((QW+1)'(quo_reg[QW][l]) + (QW+1)'(1)) >> 1;
            mag   = (qr > (QW+1)'(DELTA_CLAMP)) ? DELTA_CLAMP : qr[26:0];
            delta = sdo.neg[l] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
            if (l < 2) begin
                sum = 29'(vin[l]) - delta;
            end else begin
                sum = 29'(vin[l]) + delta;
            end
            if (!sdo.hit) begin
                vout[l] = vin[l];
            end else if (sum > VEL_MAX) begin
                vout[l] = VEL_MAX[VW-1:0];
            end else if (sum < VEL_MIN) begin
                vout[l] = VEL_MIN[VW-1:0];
            end else begin
                vout[l] = sum[VW-1:0];
            end
        end
    end

    logic [95:0] tdata_reg;
    logic        tuser_reg;
    logic        tvalid_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= {vout[3], vout[2], vout[1], vout[0]};
            tuser_reg <= sdo.hit;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl1_reg    <= 1'b0;
            vl2_reg    <= 1'b0;
            vl3_reg    <= 1'b0;
            vl4_reg    <= 1'b0;
            for (int j = 0; j <= QW; j++) vld_reg[j] <= 1'b0;
            tvalid_reg <= 1'b0;
        end else if (en) begin
            vl1_reg    <= s_tvalid;
            vl2_reg    <= vl1_reg;
            vl3_reg    <= vl2_reg;
            vl4_reg    <= vl3_reg;
            vld_reg[0] <= vl4_reg;
            for (int j = 1; j <= QW; j++) vld_reg[j] <= vld_reg[j-1];
            tvalid_reg <= vld_reg[QW];
        end
    end

    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tvalid = tvalid_reg;

endmodule

// File: hw/rtl/edcr_checker.sv
`timescale 1ns / 1ps

module edcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // An empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A taken result lets the input move in the same cycle
    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |-> s_tready)
        else $error("input stalled while output drains");

    // A stalled result stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed under stall");

endmodule

bind elastic_disc_collision_response edcr_checker u_edcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
